[design/psas_pkg.sv]
// ----------------------------------------------------------------------------
// psas_pkg
// Shared widths, constants and types of the point set axis statistics block.
// ----------------------------------------------------------------------------
package psas_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 17;
   localparam int SUM_BITS    = 33;
   localparam int SQ_BITS     = 47;
   localparam int MEAN_BITS   = 20;
   localparam int DEV_BITS    = 19;
   localparam int NUM_AXES    = 3;
   localparam logic [COUNT_BITS-1:0] MAX_POINTS = 17'd65536;
   // n*sumsq fits 64 bits, shifted by 8 it fits 72; root fits 36 bits
   localparam int PROD_BITS   = 64;
   localparam int RAD_BITS    = 72;
   localparam int ROOT_BITS   = 36;
   localparam int QDEPTH      = 2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic [COUNT_BITS-1:0]                count;
      logic                                 dropped;
      logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] mins;
      logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] maxs;
      logic [NUM_AXES-1:0][SUM_BITS-1:0]    sums;
      logic [NUM_AXES-1:0][SQ_BITS-1:0]     sqs;
   } set_stats_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_ROOT, ST_DEVDIV, ST_OUT
   } back_state_type;

endpackage

[design/psas_front.sv]
// ----------------------------------------------------------------------------
// psas_front
// Accumulates count, min, max, sum and sum of squares per axis, one point per
// cycle unless the final point stalls, and hands a finished set to the queue.
// ----------------------------------------------------------------------------
module psas_front
   import psas_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_x_value,
   input  logic signed [SAMPLE_BITS-1:0] req_y_value,
   input  logic signed [SAMPLE_BITS-1:0] req_z_value,
   input  logic                          req_final_point,
   output logic                          set_valid,
   input  logic                          set_full,
   output set_stats_type                 set_data
);

   logic [COUNT_BITS-1:0]                count_ff, count_in;
   logic                                 drop_ff, drop_in;
   logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic [NUM_AXES-1:0][SUM_BITS-1:0]    sum_ff, sum_in;
   logic [NUM_AXES-1:0][SQ_BITS-1:0]     sq_ff, sq_in;
   logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] v;
   logic                                 take, room;
   logic signed [2*SAMPLE_BITS-1:0]      prod;

   assign req_stall = req_final_point & set_full;
   assign take      = req_valid & ~req_stall;
   assign room      = (count_ff != MAX_POINTS);
   assign v         = {req_z_value, req_y_value, req_x_value};

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      prod     = '0;
      if (room) begin
         count_in = count_ff + 1'b1;
      end else begin
         drop_in = 1'b1;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         prod = $signed(v[a]) * $signed(v[a]);
         if (room) begin
            if (count_ff == '0 || $signed(v[a]) < $signed(min_ff[a])) min_in[a] = v[a];
            if (count_ff == '0 || $signed(v[a]) > $signed(max_ff[a])) max_in[a] = v[a];
            sum_in[a] = sum_ff[a] + {{(SUM_BITS-SAMPLE_BITS){v[a][SAMPLE_BITS-1]}}, v[a]};
            sq_in[a]  = sq_ff[a] + {{(SQ_BITS-2*SAMPLE_BITS){1'b0}}, prod};
         end
      end
   end

   always_comb begin
      set_valid        = take & req_final_point;
      set_data.count   = count_in;
      set_data.dropped = drop_in;
      set_data.mins    = min_in;
      set_data.maxs    = max_in;
      set_data.sums    = sum_in;
      set_data.sqs     = sq_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && req_final_point)) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         min_ff   <= '0;
         max_ff   <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else if (take) begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
      end
   end

endmodule

[design/psas_queue.sv]
// ----------------------------------------------------------------------------
// psas_queue
// Short queue of finished sets between the front and back parts.
// ----------------------------------------------------------------------------
module psas_queue
   import psas_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_valid,
   output logic          wr_full,
   input  set_stats_type wr_data,
   output logic          rd_valid,
   input  logic          rd_take,
   output set_stats_type rd_data
);

   set_stats_type        entry_ff [QDEPTH];
   logic                 wptr_ff, rptr_ff;
   logic [1:0]           level_ff;
   logic                 do_wr, do_rd;

   assign wr_full  = (level_ff == 2'(QDEPTH));
   assign rd_valid = (level_ff != 2'd0);
   assign rd_data  = entry_ff[rptr_ff];
   assign do_wr    = wr_valid & ~wr_full;
   assign do_rd    = rd_take & rd_valid;

   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         level_ff <= '0;
      end else begin
         if (do_wr) wptr_ff <= ~wptr_ff;
         if (do_rd) rptr_ff <= ~rptr_ff;
         level_ff <= level_ff + 2'(do_wr) - 2'(do_rd);
      end
   end

endmodule

[design/psas_back.sv]
// ----------------------------------------------------------------------------
// psas_back
// Per axis: mean by restoring division, deviation by a bit-serial square
// root of 256*(n*sumsq - sum^2) followed by a division by n.
// ----------------------------------------------------------------------------
module psas_back
   import psas_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          set_valid,
   output logic                          set_take,
   input  set_stats_type                 set_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_axis,
   output logic [COUNT_BITS-1:0]         rsp_point_count,
   output logic signed [SAMPLE_BITS-1:0] rsp_minimum,
   output logic signed [SAMPLE_BITS-1:0] rsp_maximum,
   output logic signed [MEAN_BITS-1:0]   rsp_mean_q4,
   output logic [DEV_BITS-1:0]           rsp_deviation_q4,
   output logic                          rsp_overflowed,
   output logic                          rsp_run_end
);

   localparam int DIVN_BITS = 40; // |16*sum| < 2^37, root < 2^36
   localparam int STEP_BITS = 7;

   back_state_type          state_ff, state_in;
   logic [1:0]              axis_ff, axis_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [PROD_BITS-1:0]    lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [RAD_BITS-1:0]     rad_ff, rad_in;
   logic [ROOT_BITS-1:0]    root_ff, root_in;
   logic [RAD_BITS-1:0]     rem_ff, rem_in;
   logic [DIVN_BITS-1:0]    quo_ff, quo_in, dvd_ff, dvd_in;
   logic [COUNT_BITS:0]     drem_ff, drem_in;
   logic                    neg_ff, neg_in;
   logic [MEAN_BITS-1:0]    mean_ff, mean_in;
   logic                    mulph_ff, mulph_in;

   logic [SUM_BITS-1:0]     sum_sel;
   logic [SUM_BITS-1:0]     sum_mag;
   logic [SQ_BITS-1:0]      sq_sel;
   logic [COUNT_BITS:0]     n_ext, drem_sh;
   logic [RAD_BITS-1:0]     rem_sh, trial;
   logic [DIVN_BITS-1:0]    s16_mag, mean_mag;

   logic                    out_valid_ff, out_valid_in;
   logic [DEV_BITS-1:0]     dev_ff, dev_in;

   assign sum_sel = set_data.sums[axis_ff];
   assign sq_sel  = set_data.sqs[axis_ff];
   assign sum_mag = sum_sel[SUM_BITS-1] ? (~sum_sel + 1'b1) : sum_sel;
   assign n_ext   = {1'b0, set_data.count};
   assign s16_mag = {{(DIVN_BITS-SUM_BITS-4){1'b0}}, sum_mag, 4'b0};
   assign drem_sh = {drem_ff[COUNT_BITS-1:0], dvd_ff[DIVN_BITS-1]};
   assign rem_sh  = {rem_ff[RAD_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial   = {root_ff[ROOT_BITS-2:0], 2'b01};
   // floor for negative: -(ceil(mag/n))
   assign mean_mag = quo_ff + ((drem_ff != '0) ? 1'b1 : 1'b0);

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      step_in      = step_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvd_in       = dvd_ff;
      drem_in      = drem_ff;
      neg_in       = neg_ff;
      mean_in      = mean_ff;
      mulph_in     = mulph_ff;
      dev_in       = dev_ff;
      out_valid_in = out_valid_ff;
      set_take     = 1'b0;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (set_valid) begin
               state_in = ST_MUL;
               axis_in  = AXIS_X;
               mulph_in = 1'b0;
            end
         end
         ST_MUL: begin
            // two registered products, one per cycle
            if (!mulph_ff) begin
               lhs_in   = PROD_BITS'(sq_sel) * PROD_BITS'(set_data.count);
               mulph_in = 1'b1;
            end else begin
               rhs_in   = PROD_BITS'(sum_mag) * PROD_BITS'(sum_mag);
               neg_in   = sum_sel[SUM_BITS-1];
               dvd_in   = s16_mag;
               drem_in  = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dvd_in = {dvd_ff[DIVN_BITS-2:0], 1'b0};
            if (drem_sh >= n_ext) begin
               drem_in = drem_sh - n_ext;
               quo_in  = {quo_ff[DIVN_BITS-2:0], 1'b1};
            end else begin
               drem_in = drem_sh;
               quo_in  = {quo_ff[DIVN_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIVN_BITS-1)) state_in = ST_ROOT;
            if (step_ff == '0) begin
               rad_in  = (rhs_ff <= lhs_ff) ? {lhs_ff - rhs_ff, 8'b0} : '0;
               root_in = '0;
               rem_in  = '0;
            end
         end
         ST_ROOT: begin
            if (step_ff == STEP_BITS'(DIVN_BITS)) begin
               mean_in = neg_ff ? MEAN_BITS'(~mean_mag + 1'b1) : MEAN_BITS'(quo_ff);
            end
            rad_in = {rad_ff[RAD_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIVN_BITS + ROOT_BITS - 1)) begin
               state_in = ST_DEVDIV;
               step_in  = '0;
            end
         end
         ST_DEVDIV: begin
            if (step_ff == '0) begin
               dvd_in  = {{(DIVN_BITS-ROOT_BITS){1'b0}}, root_ff};
               drem_in = '0;
               quo_in  = '0;
               step_in = STEP_BITS'(1);
            end else begin
               dvd_in = {dvd_ff[DIVN_BITS-2:0], 1'b0};
               if (drem_sh >= n_ext) begin
                  drem_in = drem_sh - n_ext;
                  quo_in  = {quo_ff[DIVN_BITS-2:0], 1'b1};
               end else begin
                  drem_in = drem_sh;
                  quo_in  = {quo_ff[DIVN_BITS-2:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_BITS'(DIVN_BITS)) state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               dev_in       = quo_ff[DEV_BITS-1:0];
               mulph_in     = 1'b0;
               if (axis_ff == AXIS_Z) begin
                  set_take = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         step_ff      <= '0;
         mulph_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         step_ff      <= step_in;
         mulph_ff     <= mulph_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lhs_ff  <= lhs_in;
      rhs_ff  <= rhs_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvd_ff  <= dvd_in;
      drem_ff <= drem_in;
      neg_ff  <= neg_in;
      mean_ff <= mean_in;
      dev_ff  <= dev_in;
   end

   logic [1:0]                    oaxis_ff;
   logic [COUNT_BITS-1:0]         ocnt_ff;
   logic [SAMPLE_BITS-1:0]        omin_ff, omax_ff;
   logic [MEAN_BITS-1:0]          omean_ff;
   logic                          odrop_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!out_valid_ff || !rsp_stall)) begin
         oaxis_ff <= axis_ff;
         ocnt_ff  <= set_data.count;
         omin_ff  <= set_data.mins[axis_ff];
         omax_ff  <= set_data.maxs[axis_ff];
         omean_ff <= mean_ff;
         odrop_ff <= set_data.dropped;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_axis         = oaxis_ff;
   assign rsp_point_count  = ocnt_ff;
   assign rsp_minimum      = omin_ff;
   assign rsp_maximum      = omax_ff;
   assign rsp_mean_q4      = omean_ff;
   assign rsp_deviation_q4 = dev_ff;
   assign rsp_overflowed   = odrop_ff;
   assign rsp_run_end      = (oaxis_ff == AXIS_Z);

endmodule

[design/point_set_axis_statistics.sv]
// ----------------------------------------------------------------------------
// point_set_axis_statistics
// Per-axis count, min, max, mean and standard deviation over sets of points.
// ----------------------------------------------------------------------------
// Points are taken one per cycle. The point flagged final_point closes a set;
// it stalls only while the two-entry set queue is full. Each set then passes
// through the back end axis by axis (two products, a 40-step mean division,
// a 36-step root, a division by n and one output step), returning to idle
// after the z axis and emitting the x, y and z results in that order.
module point_set_axis_statistics
   import psas_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_x_value,
   input  logic signed [SAMPLE_BITS-1:0] req_y_value,
   input  logic signed [SAMPLE_BITS-1:0] req_z_value,
   input  logic                          req_final_point,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_axis,
   output logic [COUNT_BITS-1:0]         rsp_point_count,
   output logic signed [SAMPLE_BITS-1:0] rsp_minimum,
   output logic signed [SAMPLE_BITS-1:0] rsp_maximum,
   output logic signed [MEAN_BITS-1:0]   rsp_mean_q4,
   output logic [DEV_BITS-1:0]           rsp_deviation_q4,
   output logic                          rsp_overflowed,
   output logic                          rsp_run_end
);

   logic          f_valid, f_full, q_valid, q_take;
   set_stats_type f_data, q_data;

   psas_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_x_value, .req_y_value,
      .req_z_value, .req_final_point,
      .set_valid(f_valid), .set_full(f_full), .set_data(f_data)
   );

   psas_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_full(f_full), .wr_data(f_data),
      .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
   );

   psas_back u_back (
      .clock, .reset, .set_valid(q_valid), .set_take(q_take), .set_data(q_data),
      .rsp_valid, .rsp_stall, .rsp_axis, .rsp_point_count, .rsp_minimum,
      .rsp_maximum, .rsp_mean_q4, .rsp_deviation_q4, .rsp_overflowed, .rsp_run_end
   );

`ifndef SYNTH
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_axis != 2'd3))
      else $error("axis out of range");
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_end == (rsp_axis == AXIS_Z)))
      else $error("run_end mismatch");
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_point_count != '0))
      else $error("zero count");
   a_minmax: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_minimum <= rsp_maximum))
      else $error("min above max");
`endif

endmodule
